/* hdl/ftws_pkg.sv */
// ============================================================================
// ftws_pkg
// Shared types and constants for the frame time window statistics block.
// ============================================================================
`default_nettype none

package ftws_pkg;

    // Width of one frame duration in timer ticks.
    localparam int TICKS_W  = 48;

    // Width of one converted sample (milliseconds, 8 fraction bits).
    localparam int SAMPLE_W = 32;

    // Width of ticks * 125. The factor 256000 is split into 125 * 2^11.
    localparam int PROD_W   = TICKS_W + 7;

    // Shift that completes the factor 256000 after the multiplication by 125.
    localparam int MS_SHIFT = 11;

    typedef logic [TICKS_W-1:0]  ticks_t;
    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [PROD_W-1:0]   prod_t;

endpackage : ftws_pkg

`default_nettype wire

/* hdl/ftws_cell.sv */
// ============================================================================
// ftws_cell
// One entry of the sample ring. It takes the value of its upstream neighbour
// whenever the row shifts and presents its own value downstream.
// ============================================================================
`default_nettype none

module ftws_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             shift_en,
    input  wire ftws_pkg::sample_t d_in,
    output ftws_pkg::sample_t     q_out
);
    import ftws_pkg::*;

    sample_t value_reg;
    sample_t value_next;

    // Load from the neighbour on a shift, otherwise hold.
    always_comb begin
        value_next = shift_en ? d_in : value_reg;
    end

    // The ring is cleared to zero at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else begin
            value_reg <= value_next;
        end
    end

    assign q_out = value_reg;

endmodule : ftws_cell

`default_nettype wire

/* hdl/ftws_div.sv */
// ============================================================================
// ftws_div
// Serial restoring divider, one quotient bit per cycle. The upper half of the
// dividend must be smaller than the divisor, so the quotient fits 32 bits.
// ============================================================================
`default_nettype none

module ftws_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire ftws_pkg::sample_t dividend_hi,
    input  wire ftws_pkg::sample_t dividend_lo,
    input  wire ftws_pkg::sample_t divisor,
    output logic                   done,
    output ftws_pkg::sample_t      quotient
);
    import ftws_pkg::*;

    localparam int CNT_W = $clog2(SAMPLE_W);

    sample_t            rem_reg, rem_next;
    sample_t            dq_reg, dq_next;
    sample_t            dvs_reg, dvs_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [SAMPLE_W:0]  trial;
    logic [SAMPLE_W:0]  diff;
    logic               ge;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        trial = {rem_reg, dq_reg[SAMPLE_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // Step sequencing.
    always_comb begin
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend_hi;
            dq_next   = dividend_lo;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
            dq_next  = {dq_reg[SAMPLE_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SAMPLE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule : ftws_div

`default_nettype wire

/* hdl/frame_time_window_stats.sv */
// An accepted input transaction passes the scale, check, divide, insert, ring walk,
// mean and done states before a valid result; a saturated sample skips the divide.
// A new transaction is taken only in the idle state, after the serial divide, the
// walk over all WINDOW ring entries and three multiply steps of the previous one.
// A finished result waits in the output register while the next input is taken.
// Reset (aresetn low, synchronous) clears the ring and sets timer_freq to 1000000000.
// ============================================================================
// frame_time_window_stats
// Converts frame durations in timer ticks to milliseconds with 8 fraction
// bits and reports minimum, maximum and mean over a sliding window.
// ============================================================================
`default_nettype none

module frame_time_window_stats #(
    parameter int WINDOW = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration: timer_freq
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,    // [47:0] frame_ticks
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,    // [31:0] window_min, [63:32] window_max,
                                         // [95:64] window_mean
    output logic             m_tuser     // [0] sample_saturated
);
    import ftws_pkg::*;

    localparam int CW = $clog2(WINDOW);
    localparam int SW = SAMPLE_W + CW;
    localparam logic [SAMPLE_W-1:0] FREQ_RESET = 32'd1000000000;

    // The mean is the window sum times a reciprocal of WINDOW, taken in
    // 16-bit digits of the sum, most significant digit first. With the
    // reciprocal rounded up and a shift of SW + CW the result is the exact
    // floor of sum / WINDOW for every sum the window can hold.
    localparam int DG       = 16;
    localparam int ND       = (SW + DG - 1) / DG;
    localparam int MW       = ND * DG;
    localparam int RW       = SW + 1;
    localparam int RECIP_SH = SW + CW;
    localparam int AW       = MW + RW;
    localparam int MC_W     = $clog2(ND + 1);
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << RECIP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_CHECK,
        S_CONV,
        S_INSERT,
        S_SCAN,
        S_MEAN_GO,
        S_MEAN,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    sample_t           freq_reg, freq_next;
    ticks_t            ticks_reg, ticks_next;
    prod_t             prod_reg, prod_next;
    logic              sat_reg, sat_next;
    sample_t           sample_reg, sample_next;
    logic [CW-1:0]     scan_cnt_reg, scan_cnt_next;
    sample_t           min_reg, min_next;
    sample_t           max_reg, max_next;
    logic [SW-1:0]     sum_reg, sum_next;
    logic [MW-1:0]     msrc_reg, msrc_next;
    logic [AW-1:0]     acc_reg, acc_next;
    logic [MC_W-1:0]   mcnt_reg, mcnt_next;
    logic              m_tvalid_reg, m_tvalid_next;
    sample_t           out_min_reg, out_min_next;
    sample_t           out_max_reg, out_max_next;
    sample_t           out_mean_reg, out_mean_next;
    logic              out_sat_reg, out_sat_next;

    logic [DG+RW-1:0]  part;
    logic [PROD_W+MS_SHIFT-1:0] scaled;
    logic              div_start;
    sample_t           div_hi, div_lo, div_dvs;
    logic              div_done;
    sample_t           div_q;
    logic              shift_en;
    sample_t           cell_d [WINDOW];
    sample_t           cell_q [WINDOW];
    sample_t           tail;
    logic              over;

    // Scaled dividend ticks * 256000, the saturation test against it and one
    // partial product of the mean.
    always_comb begin
        scaled = {prod_reg, {MS_SHIFT{1'b0}}};
        over   = (scaled[PROD_W+MS_SHIFT-1:SAMPLE_W]
                  >= (PROD_W+MS_SHIFT-SAMPLE_W)'(freq_reg));
        part   = msrc_reg[MW-1 -: DG] * RECIP;
        tail   = cell_q[WINDOW-1];
    end

    // Divider operands for the tick conversion.
    always_comb begin
        div_start = (state_reg == S_CHECK) && !over;
        div_hi    = scaled[2*SAMPLE_W-1:SAMPLE_W];
        div_lo    = scaled[SAMPLE_W-1:0];
        div_dvs   = freq_reg;
    end

    ftws_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (div_start),
        .dividend_hi (div_hi),
        .dividend_lo (div_lo),
        .divisor     (div_dvs),
        .done        (div_done),
        .quotient    (div_q)
    );

    // Row of ring cells: a new sample enters at the head and pushes out the
    // oldest; during the walk the tail feeds back to the head.
    assign shift_en = (state_reg == S_INSERT) || (state_reg == S_SCAN);

    always_comb begin
        cell_d[0] = (state_reg == S_INSERT) ? sample_reg : tail;
        for (int i = 1; i < WINDOW; i++) begin
            cell_d[i] = cell_q[i-1];
        end
    end

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        ftws_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .d_in     (cell_d[g]),
            .q_out    (cell_q[g])
        );
    end

    // Sequencer, statistics accumulators and output register.
    always_comb begin
        state_next    = state_reg;
        freq_next     = freq_reg;
        ticks_next    = ticks_reg;
        prod_next     = prod_reg;
        sat_next      = sat_reg;
        sample_next   = sample_reg;
        scan_cnt_next = scan_cnt_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        sum_next      = sum_reg;
        msrc_next     = msrc_reg;
        acc_next      = acc_reg;
        mcnt_next     = mcnt_reg;
        m_tvalid_next = m_tvalid_reg;
        out_min_next  = out_min_reg;
        out_max_next  = out_max_reg;
        out_mean_next = out_mean_reg;
        out_sat_next  = out_sat_reg;

        if (cfg_wr_en) begin
            freq_next = cfg_wr_data;
        end

        // A delivered result frees the output register.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ticks_next = s_tdata;
                    state_next = S_SCALE;
                end
            end
            S_SCALE: begin
                // ticks * 125 by shift and add.
                prod_next  = (PROD_W'(ticks_reg) << 7) - (PROD_W'(ticks_reg) << 2)
                             + PROD_W'(ticks_reg);
                state_next = S_SCALE == state_reg ? S_CHECK : state_reg;
            end
            S_CHECK: begin
                // A quotient of 2^32 or more, or a zero rate, saturates.
                sat_next = over;
                if (over) begin
                    sample_next = '1;
                    state_next  = S_INSERT;
                end else begin
                    state_next  = S_CONV;
                end
            end
            S_CONV: begin
                if (div_done) begin
                    sample_next = div_q;
                    state_next  = S_INSERT;
                end
            end
            S_INSERT: begin
                scan_cnt_next = '0;
                min_next      = '1;
                max_next      = '0;
                sum_next      = '0;
                state_next    = S_SCAN;
            end
            S_SCAN: begin
                // Every entry passes the tail once during the walk.
                if (tail < min_reg) begin
                    min_next = tail;
                end
                if (tail > max_reg) begin
                    max_next = tail;
                end
                sum_next      = sum_reg + SW'(tail);
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == CW'(WINDOW - 1)) begin
                    state_next = S_MEAN_GO;
                end
            end
            S_MEAN_GO: begin
                msrc_next  = MW'(sum_reg);
                acc_next   = '0;
                mcnt_next  = '0;
                state_next = S_MEAN;
            end
            S_MEAN: begin
                // One digit of the sum times the reciprocal per cycle.
                acc_next  = (acc_reg << DG) + AW'(part);
                msrc_next = msrc_reg << DG;
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == MC_W'(ND - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    out_min_next  = min_reg;
                    out_max_next  = max_reg;
                    out_mean_next = acc_reg[RECIP_SH +: SAMPLE_W];
                    out_sat_next  = sat_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            freq_reg     <= FREQ_RESET;
            m_tvalid_reg <= 1'b0;
            scan_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            freq_reg     <= freq_next;
            m_tvalid_reg <= m_tvalid_next;
            scan_cnt_reg <= scan_cnt_next;
        end
        ticks_reg    <= ticks_next;
        prod_reg     <= prod_next;
        sat_reg      <= sat_next;
        sample_reg   <= sample_next;
        min_reg      <= min_next;
        max_reg      <= max_next;
        sum_reg      <= sum_next;
        msrc_reg     <= msrc_next;
        acc_reg      <= acc_next;
        mcnt_reg     <= mcnt_next;
        out_min_reg  <= out_min_next;
        out_max_reg  <= out_max_next;
        out_mean_reg <= out_mean_next;
        out_sat_reg  <= out_sat_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_mean_reg, out_max_reg, out_min_reg};
    assign m_tuser  = out_sat_reg;

endmodule : frame_time_window_stats

`default_nettype wire

/* verif/frame_time_window_stats_test.sv */
`timescale 1ns / 100ps
// ============================================================================
// frame_time_window_stats_test
// Self-checking bench for the frame time window statistics block. Frame
// durations go in on the input stream and an in-bench model of the tick
// conversion and the sample ring predicts min, max, mean and the clamp flag.
// Each result transaction is compared with the oldest prediction. Directed
// frames cover the conversion limits and odd timer rates. Randomised bursts of
// steady, spiky and saturating frames then run under three idle patterns.
// ============================================================================
module frame_time_window_stats_test;
    import ftws_pkg::*;

    localparam int WINDOW_LEN     = 64;
    // Longest input-to-result latency of the block plus some margin.
    localparam int SETTLE_CYCLES  = WINDOW_LEN + 80;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam longint unsigned MS_FACTOR = 256000;
    localparam sample_t SAT_VALUE  = '1;
    localparam sample_t RESET_RATE = 32'd1_000_000_000;
    localparam ticks_t  TICKS_MAX  = '1;

    // Burst styles for the random traffic.
    typedef enum int {
        FRAMES_STEADY,
        FRAMES_SPIKE,
        FRAMES_NEAR_CLAMP,
        FRAMES_CLAMPED,
        FRAMES_NOISE
    } frame_style_e;

    typedef struct packed {
        sample_t lo;
        sample_t hi;
        sample_t mean;
        logic    sat;
    } window_stats_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = RESET_RATE;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    ticks_t      s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tuser;

    // Model state: ring of converted samples, write position and timer rate.
    sample_t       frame_ring [WINDOW_LEN] = '{default: '0};
    int unsigned   ring_wr  = 0;
    sample_t       rate_now = RESET_RATE;
    window_stats_t pending_stats [$];

    int unsigned src_idle_pct    = 0;
    int unsigned snk_idle_pct    = 0;
    int unsigned frames_sent     = 0;
    int unsigned results_checked = 0;
    int unsigned clamped_results = 0;
    int unsigned rate_writes     = 0;
    int unsigned mismatches      = 0;
    int unsigned cycles          = 0;

    frame_time_window_stats #(
        .WINDOW      (WINDOW_LEN)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // [47:0] frame_ticks
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // [31:0] window_min, [63:32] window_max,
                                    // [95:64] window_mean
        .m_tuser     (m_tuser)      // [0] sample_saturated
    );

    // Clock generation.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit in case the block stops responding.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Exact ticks * 256000 / rate with clamping at 32 bits; a zero rate clamps.
    function automatic sample_t to_fixed_ms(input ticks_t ticks, input sample_t rate,
                                            output logic clamped);
        longint unsigned quo;
        longint unsigned rem;
        longint unsigned whole;
        clamped = 1'b1;
        if (rate == '0)
            return SAT_VALUE;
        quo = ticks / rate;
        rem = ticks % rate;
        if (quo > SAT_VALUE)
            return SAT_VALUE;
        whole = quo * MS_FACTOR + (rem * MS_FACTOR) / rate;
        if (whole > SAT_VALUE)
            return SAT_VALUE;
        clamped = 1'b0;
        return sample_t'(whole);
    endfunction

    // Store one frame in the ring and queue the statistics it should produce.
    function automatic void record_frame(input ticks_t ticks);
        window_stats_t   st;
        logic            clamped;
        longint unsigned total;
        frame_ring[ring_wr] = to_fixed_ms(ticks, rate_now, clamped);
        ring_wr = (ring_wr + 1) % WINDOW_LEN;
        st.lo   = SAT_VALUE;
        st.hi   = '0;
        st.sat  = clamped;
        total   = 0;
        foreach (frame_ring[i]) begin
            if (frame_ring[i] < st.lo)
                st.lo = frame_ring[i];
            if (frame_ring[i] > st.hi)
                st.hi = frame_ring[i];
            total += frame_ring[i];
        end
        st.mean = sample_t'(total / WINDOW_LEN);
        pending_stats.push_back(st);
    endfunction

    function automatic void check_field(input string name, input sample_t want,
                                        input sample_t got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Pick a frame duration of the given style at the current timer rate.
    function automatic ticks_t pick_ticks(input frame_style_e style, input int fps);
        longint unsigned nominal;
        longint unsigned span;
        bit [95:0]       first_clamp;
        // Smallest tick count whose converted sample no longer fits 32 bits.
        first_clamp = ((96'd1 << 32) * rate_now + 96'd255999) / 96'd256000;
        nominal     = rate_now / fps;
        case (style)
            FRAMES_STEADY: begin
                return ticks_t'(nominal - nominal / 16
                                + (nominal / 8) * $urandom_range(0, 1000) / 1000);
            end
            FRAMES_SPIKE: begin
                return ticks_t'(nominal * $urandom_range(2, 40));
            end
            FRAMES_NEAR_CLAMP: begin
                if (first_clamp < 2)
                    return ticks_t'($urandom_range(0, 3));
                return ticks_t'(first_clamp - 2 + $urandom_range(0, 3));
            end
            FRAMES_CLAMPED: begin
                span = TICKS_MAX - first_clamp + 1;
                return ticks_t'(first_clamp + {$urandom, $urandom} % span);
            end
            default: begin
                return ticks_t'({$urandom, $urandom}) >> $urandom_range(0, 47);
            end
        endcase
    endfunction

    // Present one frame and wait for its transaction; tvalid stays high after it.
    task automatic send_frame(input ticks_t ticks);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ticks;
        do
            @(posedge aclk);
        while (!s_tready);
        record_frame(ticks);
        frames_sent++;
    endtask

    // Write timer_freq once the block has drained.
    task automatic set_timer_rate(input sample_t rate);
        s_tvalid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rate;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        rate_now = rate;
        rate_writes++;
    endtask

    // Result checking and receiver back-pressure.
    always @(posedge aclk) begin : result_check
        window_stats_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_stats.size() == 0) begin
                $error("result transaction with no frame outstanding");
                mismatches++;
            end else begin
                want = pending_stats.pop_front();
                check_field("window_min", want.lo, m_tdata[31:0]);
                check_field("window_max", want.hi, m_tdata[63:32]);
                check_field("window_mean", want.mean, m_tdata[95:64]);
                check_field("sample_saturated", sample_t'(want.sat), sample_t'(m_tuser));
                results_checked++;
                if (m_tuser)
                    clamped_results++;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Cleared ring at the reset rate, then the exact clamp boundary.
    task automatic test_power_up_window();
        send_frame('0);
        send_frame(48'd16_666_667);
        send_frame(48'd16_777_215_999_999);
        send_frame(48'd16_777_216_000_000);
        send_frame(TICKS_MAX);
        send_frame(48'h0000_5555_5555);
        send_frame(48'h0000_AAAA_AAAA);
    endtask

    // Slowest and fastest timer: product clamp, quotient clamp and exact values.
    task automatic test_rate_extremes();
        set_timer_rate(32'd1);
        send_frame(48'd1);
        send_frame(48'd16_777);
        send_frame(48'd16_778);
        send_frame(48'h0001_0000_0000);
        set_timer_rate(32'hFFFF_FFFF);
        send_frame(48'h0000_FFFF_FFFF);
        send_frame(48'h0000_FFFF_FFFE);
        send_frame(TICKS_MAX);
    endtask

    // A zero rate clamps every sample, even a zero duration.
    task automatic test_zero_rate();
        set_timer_rate('0);
        send_frame('0);
        send_frame(48'd1);
    endtask

    // Random bursts of frames at one timer rate under one idle pattern.
    task automatic test_frame_traffic(input sample_t rate, input int unsigned src_pct,
                                      input int unsigned snk_pct, input int n_frames);
        int           left;
        int           run;
        int           fps;
        frame_style_e style;
        set_timer_rate(rate);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        left = n_frames;
        while (left > 0) begin
            run = $urandom_range(1, 80);
            if (run > left)
                run = left;
            case ($urandom_range(0, 7))
                0, 1, 2, 3: style = FRAMES_STEADY;
                4:          style = FRAMES_SPIKE;
                5:          style = FRAMES_NEAR_CLAMP;
                6:          style = FRAMES_CLAMPED;
                default:    style = FRAMES_NOISE;
            endcase
            case ($urandom_range(0, 5))
                0:       fps = 24;
                1:       fps = 30;
                2:       fps = 60;
                3:       fps = 144;
                4:       fps = 240;
                default: fps = 1000;
            endcase
            repeat (run) send_frame(pick_ticks(style, fps));
            left -= run;
        end
    endtask

    // More than a whole window of clamped samples drives all statistics to full scale.
    task automatic test_clamped_window();
        set_timer_rate(32'd10_000_000);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (WINDOW_LEN + 6) send_frame(pick_ticks(FRAMES_CLAMPED, 60));
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 24;
        snk_idle_pct = 85;
        test_power_up_window();
        test_rate_extremes();
        test_zero_rate();
        test_frame_traffic(RESET_RATE, 24, 85, 180);
        test_frame_traffic($urandom_range(1, 32'hFFFF_FFFF), 85, 24, 180);
        test_frame_traffic($urandom_range(1000, 100_000_000), 0, 0, 110);
        test_clamped_window();

        // Drain the block before the verdict.
        s_tvalid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("summary: %0d frames sent, %0d results checked, %0d clamped, %0d rate writes",
                 frames_sent, results_checked, clamped_results, rate_writes);
        $display("summary: zero and extreme timer rates, clamp boundaries, full windows, %s",
                 "three idle patterns");
        if (mismatches == 0 && pending_stats.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
hdl/ftws_pkg.sv
hdl/ftws_cell.sv
hdl/ftws_div.sv
hdl/frame_time_window_stats.sv
verif/frame_time_window_stats_test.sv
